// File: hdl/box_downscale_2x2_average_assert.svh
// Assertion macros used by the checker file of the downscaler.
`ifndef BOX_DOWNSCALE_2X2_AVERAGE_ASSERT_SVH
`define BOX_DOWNSCALE_2X2_AVERAGE_ASSERT_SVH

// Clocked assertion that is switched off while the asynchronous reset is low.
`define BDS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define BDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/bds_pkg.sv
`default_nettype none

package bds_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

	typedef logic [PIX_W-1:0] pix_t;

	// Rounded mean of two pixels, (a + b + 1) >> 1.
	function automatic pix_t avg_round(input pix_t a, input pix_t b);
		logic [PIX_W:0] sum;
		sum = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
		return sum[PIX_W:1];
	endfunction

endpackage

`default_nettype wire

// File: hdl/box_downscale_2x2_average.sv
// Half-size 2x2 box downscaler for a raster stream of 8-bit grey pixels.
// Input beats (pixel_in, in_valid/in_ready) carry one pixel each, row by row.
// Even rows are written into an on-chip line memory. On the odd row that
// follows, each pixel is averaged with the stored pixel above it, the result
// of each even column is held, and on the next odd column the two vertical
// means are averaged again to give one output beat (pixel_out, end_of_row,
// end_of_frame on out_valid/out_ready). Only the part of each row below the
// largest multiple of 16 is used, and a trailing odd row gives no output.
// Throughput is one input beat per clock while the output is not stalled. An
// output beat passes from the input beat that completes its 2x2 block through
// the synchronous line memory read stage and then the output register.
// While the receiver stalls, the output register holds its beat and one more
// input beat is taken into the read stage; after that in_ready drops until
// the output register is emptied.
// Reset clears counters, the held average and all valid flags and loads the
// register defaults (640 x 480). The line memory is not cleared: odd rows only
// read entries that the even row before them wrote. The registers are written
// through cfg_we/cfg_index/cfg_data and must only change while the block is
// idle.
`default_nettype none

module box_downscale_2x2_average #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bds_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [bds_pkg::PIX_W-1:0]      pixel_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [bds_pkg::PIX_W-1:0]           pixel_out,
	output logic                                end_of_row,
	output logic                                end_of_frame
);
	import bds_pkg::*;

	// Column counter and memory address width.
	localparam int CW = $clog2(MAX_WIDTH);
	// Width used for row length comparisons.
	localparam int LW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int RW = CFG_W + 1;
	localparam logic [LW-1:0] MAX_W_L = LW'(MAX_WIDTH);

	// Control carried alongside a beat in the memory read stage.
	typedef struct packed {
		logic vert;      // odd row inside the used window
		logic col_odd;   // second column of a pair
		logic eor;
		logic eof;
	} s1_ctl_t;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CW-1:0]    col_q;
	logic [CFG_W-1:0] row_q;
	pix_t             held_q;

	pix_t             line_mem_q [MAX_WIDTH];

	logic             v_s1;
	s1_ctl_t          ctl_s1;
	pix_t             pix_s1;
	pix_t             rd_s1;

	logic             out_valid_q;
	pix_t             pixel_out_q;
	logic             eor_q;
	logic             eof_q;

	logic [LW-1:0]    width_l;
	logic [LW-1:0]    row_len;
	logic [LW-1:0]    used_w;
	logic [CFG_W-1:0] used_h;
	logic [LW-1:0]    col_l;
	logic [LW-1:0]    col_nxt_l;
	logic [RW-1:0]    row_nxt;
	logic             active;
	logic             in_win;
	logic             acc;
	logic             mem_we;
	logic             mem_re;
	logic             advance;
	logic             eor_c;
	logic             eof_c;
	pix_t             vavg;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMAGE_WIDTH_RST;
			height_q <= IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame geometry and position decode for the incoming beat.
	always_comb begin
		width_l   = LW'(width_q);
		row_len   = (width_l > MAX_W_L) ? MAX_W_L : width_l;
		used_w    = {row_len[LW-1:4], 4'b0000};
		used_h    = {height_q[CFG_W-1:1], 1'b0};
		col_l     = LW'(col_q);
		col_nxt_l = col_l + LW'(1);
		row_nxt   = {1'b0, row_q} + RW'(1);
		active    = (row_len != '0) && (height_q != '0);
		in_win    = (col_l < used_w) && (row_q < used_h);
		eor_c     = (col_nxt_l == used_w);
		eof_c     = eor_c && (row_nxt == {1'b0, used_h});
	end

	// The pipeline moves when the output register is free or being emptied.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !v_s1 || advance;
	assign acc      = in_valid && in_ready;
	assign mem_we   = acc && active && in_win && !row_q[0];
	assign mem_re   = acc && active && in_win && row_q[0];

	// Column and row counters; an ignored beat leaves them unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc && active) begin
			if (col_nxt_l >= row_len) begin
				col_q <= '0;
				if (row_nxt >= {1'b0, height_q}) begin
					row_q <= '0;
				end else begin
					row_q <= row_nxt[CFG_W-1:0];
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Line memory: even rows write, odd rows read into the read stage ahead of use.
	// A read always follows the write of its entry by a full row, so no
	// forwarding is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem_q[col_q] <= pixel_in;
		end
		if (mem_re) begin
			rd_s1 <= line_mem_q[col_q];
		end
	end

	// Read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1         <= pixel_in;
			ctl_s1.vert    <= active && in_win && row_q[0];
			ctl_s1.col_odd <= col_q[0];
			ctl_s1.eor     <= eor_c;
			ctl_s1.eof     <= eof_c;
		end
	end

	assign vavg = avg_round(rd_s1, pix_s1);

	// Held vertical mean of the even column of a pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (v_s1 && advance && ctl_s1.vert && !ctl_s1.col_odd) begin
			held_q <= vavg;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s1 && ctl_s1.vert && ctl_s1.col_odd;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1 && ctl_s1.vert && ctl_s1.col_odd) begin
			pixel_out_q <= avg_round(held_q, vavg);
			eor_q       <= ctl_s1.eor;
			eof_q       <= ctl_s1.eof;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_out    = pixel_out_q;
	assign end_of_row   = eor_q;
	assign end_of_frame = eof_q;

endmodule

`default_nettype wire

// File: hdl/bds_checker.sv
`default_nettype none

`include "box_downscale_2x2_average_assert.svh"

module bds_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic                      in_ready,
	input  wire logic                      out_valid,
	input  wire logic                      out_ready,
	input  wire logic [bds_pkg::PIX_W-1:0] pixel_out,
	input  wire logic                      end_of_row,
	input  wire logic                      end_of_frame
);
	import bds_pkg::*;

	// A stalled output beat keeps its payload.
	`BDS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(end_of_row) && $stable(end_of_frame), "output beat changed while stalled")

	// The last beat of a frame also closes its row.
	`BDS_ASSERT(a_eof_eor, clk, arst_n, out_valid && end_of_frame |-> end_of_row, "end_of_frame without end_of_row")

	// A new output beat only follows an input beat taken through the read stage.
	`BDS_ASSERT(a_out_cause, clk, arst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "output beat without a preceding input beat")

	// Input is only held off while the output is full and stalled.
	`BDS_ASSERT(a_ready_stall, clk, arst_n, !in_ready |-> out_valid && !out_ready, "in_ready low without an output stall")

endmodule

bind box_downscale_2x2_average bds_checker u_bds_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.pixel_out    (pixel_out),
	.end_of_row   (end_of_row),
	.end_of_frame (end_of_frame)
);

`default_nettype wire

// File: sim/box_downscale_2x2_average_tb.sv
`default_nettype none

module box_downscale_2x2_average_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import bds_pkg::*;

	// Depth of the line memory in the instance (its default MAX_WIDTH).
	localparam int LINE_DEPTH = 2048;
	// Cycles allowed after the last expected beat before the block counts as idle.
	// The output trails its input beat through the read stage and the output register.
	localparam int DRAIN_CYCLES = 4;
	// Lower bound on the counted input beats in the random part.
	localparam int RANDOM_PIXELS = 700;
	// Length of the long receiver stall in the backpressure test.
	localparam int LONG_HOLD_CYCLES = 300;

	// One output beat as the block should present it.
	typedef struct packed {
		pix_t pixel;
		logic row_end;
		logic frame_end;
	} half_pixel_t;

	// Upper and lower rows of the directed frame. Together they hit both extremes,
	// every bit in both states, and sums that are odd so that rounding matters.
	localparam pix_t DIRECTED_UPPER [16] = '{
		8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00, 8'h01, 8'h02,
		8'h80, 8'h7f, 8'hff, 8'hfe, 8'h00, 8'h01, 8'haa, 8'h55
	};
	localparam pix_t DIRECTED_LOWER [16] = '{
		8'h00, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h02, 8'h01,
		8'h7f, 8'h80, 8'hfe, 8'hff, 8'h01, 8'h00, 8'h55, 8'haa
	};

	// All inputs of the block start at known values.
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	pix_t                 pixel_in  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	pix_t                 pixel_out;
	logic                 end_of_row;
	logic                 end_of_frame;

	box_downscale_2x2_average dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_in     (pixel_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_out    (pixel_out),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mirror of the block's state, updated on every accepted input beat.
	logic [CFG_W-1:0] width_reg  = IMAGE_WIDTH_RST;
	logic [CFG_W-1:0] height_reg = IMAGE_HEIGHT_RST;
	pix_t             line_store [LINE_DEPTH];
	int unsigned      col_count  = 0;
	int unsigned      row_count  = 0;
	pix_t             held_mean  = '0;

	// Output beats predicted but not yet seen, oldest first.
	half_pixel_t pending_outputs [$];

	int unsigned pixels_counted = 0;
	int unsigned mismatch_count = 0;

	// Idling controls shared between the test tasks and the two handshake sides.
	bit          sender_idles   = 1'b1;
	bit          receiver_idles = 1'b1;
	int unsigned hold_request   = 0;

	function automatic pix_t round_mean(input pix_t a, input pix_t b);
		return pix_t'((int'(a) + int'(b) + 1) >> 1);
	endfunction

	// Advances the mirrored state by one input pixel and queues the output beat,
	// if this pixel completes a 2x2 block.
	function automatic void downscale_pixel(input pix_t pix);
		int unsigned row_len;
		int unsigned used_w;
		int unsigned used_h;
		int unsigned col;
		int unsigned row;
		pix_t        vert;
		half_pixel_t beat;
		// Rows longer than the line memory are treated as exactly that long.
		row_len = (width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg);
		used_w  = (row_len / 16) * 16;
		used_h  = (int'(height_reg) / 2) * 2;
		col     = col_count;
		row     = row_count;
		// A zero width or height makes the block swallow the pixel without counting it.
		if (row_len == 0 || height_reg == 0)
			return;
		pixels_counted++;
		if (col < used_w && row < used_h) begin
			if (row % 2 == 0) begin
				line_store[col] = pix;
			end else begin
				vert = round_mean(line_store[col], pix);
				if (col % 2 == 0) begin
					held_mean = vert;
				end else begin
					beat.pixel     = round_mean(held_mean, vert);
					beat.row_end   = (col + 1 == used_w);
					beat.frame_end = beat.row_end && (row + 1 == used_h);
					pending_outputs.push_back(beat);
				end
			end
		end
		// Counters wrap against the full row length, not the used width, so a
		// counter already past a freshly lowered limit wraps after this pixel.
		if (col + 1 >= row_len) begin
			col_count = 0;
			row_count = (row + 1 >= height_reg) ? 0 : row + 1;
		end else begin
			col_count = col + 1;
		end
	endfunction

	function automatic pix_t draw_pixel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Offers one input beat, after a random gap while sender_idles is set, and waits until the block takes it.
	task automatic send_pixel(input pix_t pix);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 11) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		downscale_pixel(pix);
	endtask

	task automatic send_random_pixels(input int unsigned count);
		repeat (count) send_pixel(draw_pixel());
	endtask

	// Feeds pixels until the frame counters are back at zero. Only called while
	// both sizes are nonzero, since otherwise the counters never move.
	task automatic finish_frame();
		while (col_count != 0 || row_count != 0)
			send_pixel(draw_pixel());
	endtask

	// Stops offering input and waits for every predicted beat, then lets the
	// pipeline drain of any pixel that produced nothing.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_IMAGE_WIDTH:  width_reg  = value;
			REG_IMAGE_HEIGHT: height_reg = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Both registers are rewritten only once the block has gone quiet.
	task automatic set_size(input int unsigned w, input int unsigned h);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
	endtask

	// Receiving side. For every beat it draws a stall, then takes the beat and
	// compares it with the oldest prediction. A long hold asked for by a test
	// replaces the drawn stall once.
	initial begin : output_checker
		int unsigned stall;
		half_pixel_t want;
		forever begin
			stall = receiver_idles ? $urandom_range(0, 11) : 0;
			if (hold_request != 0) begin
				stall        = hold_request;
				hold_request = 0;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			if (pending_outputs.size() == 0) begin
				$display("%0t: output beat with nothing expected: pixel_out=%0h eor=%b eof=%b",
					$time, pixel_out, end_of_row, end_of_frame);
				mismatch_count++;
			end else begin
				want = pending_outputs.pop_front();
				if (pixel_out !== want.pixel) begin
					$display("%0t: pixel_out expected %0h, got %0h", $time, want.pixel, pixel_out);
					mismatch_count++;
				end
				if (end_of_row !== want.row_end) begin
					$display("%0t: end_of_row expected %b, got %b", $time, want.row_end, end_of_row);
					mismatch_count++;
				end
				if (end_of_frame !== want.frame_end) begin
					$display("%0t: end_of_frame expected %b, got %b", $time, want.frame_end,
						end_of_frame);
					mismatch_count++;
				end
			end
		end
	end

	// One 16x2 frame with hand-picked values: the smallest size that makes output.
	task automatic test_rounding_extremes();
		set_size(16, 2);
		for (int c = 0; c < 16; c++) send_pixel(DIRECTED_UPPER[c]);
		for (int c = 0; c < 16; c++) send_pixel(DIRECTED_LOWER[c]);
	endtask

	// One frame as wide as any used later. It writes the start of the line
	// memory, so later tests that change the size in mid-frame never read an
	// entry that was never written.
	task automatic test_widest_frame();
		set_size(80, 2);
		send_random_pixels(80 * 2);
	endtask

	// Sizes that consume pixels but produce nothing.
	task automatic test_sizes_without_output();
		// Zero width or zero height: pixels are dropped and counters stay put.
		set_size(0, 4);
		send_random_pixels(8);
		set_size(16, 0);
		send_random_pixels(8);
		set_size(0, 0);
		send_random_pixels(4);
		// Rows shorter than 16 pixels are counted but never used.
		set_size(15, 2);
		send_random_pixels(30);
		set_size(1, 2);
		send_random_pixels(2);
	endtask

	// Widths that are not a multiple of 16, odd heights, the tallest frame and
	// size changes in the middle of a frame.
	task automatic test_ragged_and_resized();
		// Columns 32..36 are dropped and the fifth row gives nothing.
		set_size(37, 5);
		send_random_pixels(37 * 5);
		// Tallest frame, cut short: the row counter sits past the new height and
		// wraps at the end of the current row.
		set_size(16, 4095);
		send_random_pixels(16 * 3);
		set_size(16, 2);
		finish_frame();
		// Width lowered while the column counter is already past it, in an odd row.
		set_size(64, 4);
		send_random_pixels(64 + 40);
		set_size(32, 4);
		finish_frame();
		// Width raised in mid-frame.
		set_size(32, 4);
		send_random_pixels(32 + 10);
		set_size(48, 4);
		finish_frame();
	endtask

	// The receiver stops for a long while as the sender keeps pushing with no
	// gaps, so the block fills and must hold off its input.
	task automatic test_output_backpressure();
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		set_size(32, 4);
		hold_request = LONG_HOLD_CYCLES;
		send_random_pixels(32 * 4);
		wait_idle();
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	// Mostly complete frames of random small sizes, with some sizes that make
	// no output and some frames that are resized partway through.
	task automatic test_random_frames();
		int unsigned start;
		int unsigned w;
		int unsigned h;
		start = pixels_counted;
		while (pixels_counted - start < RANDOM_PIXELS) begin
			sender_idles   = ($urandom_range(0, 3) != 0);
			receiver_idles = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				7: begin
					case ($urandom_range(0, 2))
						0: begin
							w = $urandom_range(0, 15);
							h = $urandom_range(0, 5);
						end
						1: begin
							w = $urandom_range(16, 64);
							h = $urandom_range(0, 1);
						end
						default: begin
							w = $urandom_range(16, 64);
							h = 2 * $urandom_range(1, 2) + 1;
						end
					endcase
					set_size(w, h);
					send_random_pixels($urandom_range(1, 40));
					if (w != 0 && h != 0)
						finish_frame();
				end
				8, 9: begin
					w = $urandom_range(16, 80);
					h = $urandom_range(2, 6);
					set_size(w, h);
					send_random_pixels($urandom_range(1, w * h - 1));
					set_size($urandom_range(1, 80), $urandom_range(1, 6));
					finish_frame();
				end
				default: begin
					w = $urandom_range(16, 80);
					if ($urandom_range(0, 2) == 0)
						w = (w / 16) * 16;
					h = $urandom_range(2, 6);
					set_size(w, h);
					send_random_pixels(w * h);
				end
			endcase
		end
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	initial begin : stimulus
		int unsigned waited;
		foreach (line_store[i]) line_store[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rounding_extremes();
		test_widest_frame();
		test_sizes_without_output();
		test_ragged_and_resized();
		test_output_backpressure();
		test_random_frames();

		// Drain, with a bound so that a lost beat is reported here.
		in_valid <= 1'b0;
		waited = 0;
		while (pending_outputs.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_outputs.size() != 0) begin
			$display("%0t: %0d expected output beats never arrived", $time,
				pending_outputs.size());
			mismatch_count += pending_outputs.size();
		end
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// The slowest correct run stays well below this bound.
	initial begin : watchdog
		#18_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
